### rtl/core/lah_pkg.sv
`timescale 1ns / 1ps

package lah_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W = 16;
    localparam int HASH_W = 2 * SUM_W;

    localparam logic [SUM_W-1:0] MODULUS = 16'd65521;

    localparam logic [BYTE_W-1:0] UPPER_FIRST = 8'd65;
    localparam logic [BYTE_W-1:0] UPPER_LAST = 8'd90;
    localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

    typedef struct packed {
        logic [SUM_W-1:0] low_sum;
        logic [SUM_W-1:0] high_sum;
    } sums_t;

endpackage

### rtl/core/lah_char_if.sv
`timescale 1ns / 1ps

interface lah_char_if;
    logic                           valid;
    logic                           ready;
    logic [lah_pkg::BYTE_W-1:0]     data_byte;
    logic                           end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

### rtl/core/lah_hash_if.sv
`timescale 1ns / 1ps

interface lah_hash_if;
    logic                           valid;
    logic                           ready;
    logic [lah_pkg::HASH_W-1:0]     hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink (input valid, input hash_value, output ready);
endinterface

### rtl/core/lah_sum_update.sv
`timescale 1ns / 1ps

module lah_sum_update (
    input  lah_pkg::sums_t                  sums,
    input  logic [lah_pkg::BYTE_W-1:0]      data_byte,
    output lah_pkg::sums_t                  sums_next
);

    logic [lah_pkg::BYTE_W-1:0]     folded;
    logic [lah_pkg::SUM_W:0]        low_raw;
    logic [lah_pkg::SUM_W:0]        high_raw;
    logic [lah_pkg::SUM_W:0]        modulus_ext;
    logic [lah_pkg::SUM_W-1:0]      low_new;
    logic [lah_pkg::SUM_W-1:0]      high_new;

    assign modulus_ext = {1'b0, lah_pkg::MODULUS};

    // map A-Z onto a-z
    always_comb
    begin
        if (data_byte >= lah_pkg::UPPER_FIRST && data_byte <= lah_pkg::UPPER_LAST)
        begin
            folded = data_byte + lah_pkg::CASE_OFFSET;
        end
        else
        begin
            folded = data_byte;
        end
    end

    always_comb
    begin
        low_raw = {1'b0, sums.low_sum}
                  + {{(lah_pkg::SUM_W + 1 - lah_pkg::BYTE_W){1'b0}}, folded};
        if (low_raw >= modulus_ext)
        begin
            low_new = lah_pkg::SUM_W'(low_raw - modulus_ext);
        end
        else
        begin
            low_new = low_raw[lah_pkg::SUM_W-1:0];
        end

        high_raw = {1'b0, sums.high_sum} + {1'b0, low_new};
        if (high_raw >= modulus_ext)
        begin
            high_new = lah_pkg::SUM_W'(high_raw - modulus_ext);
        end
        else
        begin
            high_new = high_raw[lah_pkg::SUM_W-1:0];
        end
    end

    assign sums_next.low_sum = low_new;
    assign sums_next.high_sum = high_new;

endmodule

### rtl/core/lowercase_adler_hash.sv
`timescale 1ns / 1ps
// hash_value goes valid as the last byte moves from the byte stage into the output register,
// which waits while an earlier hash item is still waiting to be taken
// throughput: one byte per cycle while no hash item waits, set by the update of the two sums
// a hash item waiting to be taken stalls the byte stage; input stops once it holds a byte
// reset: rst_n clears both sums and all valid flags at once

module lowercase_adler_hash (
    input  logic                clk,
    input  logic                rst_n,
    lah_char_if.sink            char_stream,
    lah_hash_if.source          hash_stream
);

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [lah_pkg::BYTE_W-1:0]     s1_byte_reg;
    logic                           s1_last_reg;

    lah_pkg::sums_t                 sums_reg;
    lah_pkg::sums_t                 sums_next;
    lah_pkg::sums_t                 sums_upd;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [lah_pkg::HASH_W-1:0]     hash_reg;

    logic                           advance;
    logic                           take_in;
    logic                           process;

    assign advance = !out_valid_reg || hash_stream.ready;
    assign process = s1_valid_reg && advance;
    assign char_stream.ready = !s1_valid_reg || advance;
    assign take_in = char_stream.valid && char_stream.ready;

    lah_sum_update u_sum_update (
        .sums      (sums_reg),
        .data_byte (s1_byte_reg),
        .sums_next (sums_upd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take_in)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        sums_next = sums_reg;
        if (process)
        begin
            if (s1_last_reg)
            begin
                sums_next = '0;
            end
            else
            begin
                sums_next = sums_upd;
            end
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg && s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sums_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            sums_reg <= sums_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_byte_reg <= char_stream.data_byte;
            s1_last_reg <= char_stream.end_of_string;
        end
        if (process && s1_last_reg)
        begin
            hash_reg <= {sums_upd.high_sum, sums_upd.low_sum};
        end
    end

    assign hash_stream.valid = out_valid_reg;
    assign hash_stream.hash_value = hash_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sums_reg.low_sum < lah_pkg::MODULUS && sums_reg.high_sum < lah_pkg::MODULUS)
        else $error("running sum out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && s1_last_reg) |=> (sums_reg == '0 && out_valid_reg))
        else $error("sums not cleared or result missing after last byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (process && !s1_last_reg && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced for a byte that is not last");

endmodule

### sim/lah_hash_checker.sv
`timescale 1ns / 1ps

module lah_hash_checker (
    input  logic    clk,
    input  logic    rst_n,
    lah_char_if     char_mon,
    lah_hash_if     hash_mon,
    input  logic    end_of_run,
    output int      pending_count,
    output int      fail_count
);

    logic [lah_pkg::SUM_W-1:0]   low_acc = '0;
    logic [lah_pkg::SUM_W-1:0]   high_acc = '0;
    logic [lah_pkg::HASH_W-1:0]  expected_hashes[$];
    int                          waiting = 0;
    int                          mismatches = 0;
    bit                          leftover_checked = 1'b0;

    assign pending_count = waiting;
    assign fail_count = mismatches;

    function automatic logic [lah_pkg::SUM_W-1:0] fold_upper(
        input logic [lah_pkg::BYTE_W-1:0] b);
        if (b >= lah_pkg::UPPER_FIRST && b <= lah_pkg::UPPER_LAST)
        begin
            return lah_pkg::SUM_W'(b) + lah_pkg::SUM_W'(lah_pkg::CASE_OFFSET);
        end
        return lah_pkg::SUM_W'(b);
    endfunction

    function automatic logic [lah_pkg::SUM_W-1:0] mod_add(
        input logic [lah_pkg::SUM_W-1:0] a,
        input logic [lah_pkg::SUM_W-1:0] b);
        logic [lah_pkg::SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, lah_pkg::MODULUS})
        begin
            s = s - {1'b0, lah_pkg::MODULUS};
        end
        return s[lah_pkg::SUM_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        logic [lah_pkg::HASH_W-1:0] want;
        if (rst_n)
        begin
            if (hash_mon.valid && hash_mon.ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    report_mismatch($sformatf("hash_value %h with no item pending",
                                              hash_mon.hash_value));
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_mon.hash_value !== want)
                    begin
                        report_mismatch($sformatf("hash_value %h, expected %h",
                                                  hash_mon.hash_value, want));
                    end
                end
            end
            if (char_mon.valid && char_mon.ready)
            begin
                low_acc = mod_add(low_acc, fold_upper(char_mon.data_byte));
                high_acc = mod_add(high_acc, low_acc);
                if (char_mon.end_of_string)
                begin
                    expected_hashes.insert(expected_hashes.size(), {high_acc, low_acc});
                    low_acc = '0;
                    high_acc = '0;
                end
            end
            if (end_of_run && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (expected_hashes.size() != 0)
                begin
                    report_mismatch($sformatf("%0d hash items never arrived",
                                              expected_hashes.size()));
                end
            end
            waiting = expected_hashes.size();
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

    logic   clk;
    logic   rst_n = 1'b0;
    logic   end_of_run = 1'b0;
    int     pending_count;
    int     fail_count;
    int     bytes_sent = 0;
    bit     idling_on = 1'b1;
    bit     pressure_done = 1'b0;

    lah_char_if char_bus ();
    lah_hash_if hash_bus ();

    lowercase_adler_hash uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_bus),
        .hash_stream (hash_bus)
    );

    lah_hash_checker hash_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_mon      (char_bus),
        .hash_mon      (hash_bus),
        .end_of_run    (end_of_run),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL lowercase_adler_hash");
        $finish;
    end

    // receiver stalls
    initial
    begin
        hash_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idling_on && $urandom_range(0, 7) == 0)
            begin
                hash_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            hash_bus.ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [lah_pkg::BYTE_W-1:0] b, input logic last);
        char_bus.valid <= 1'b1;
        char_bus.data_byte <= b;
        char_bus.end_of_string <= last;
        do @(posedge clk); while (!char_bus.ready);
        bytes_sent++;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            char_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (char_bus.valid)
        begin
            char_bus.valid <= 1'b0;
        end
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    function automatic logic [lah_pkg::BYTE_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 199);
        if (roll == 0)
        begin
            return '0;
        end
        case (roll % 10)
            0, 1, 2: return lah_pkg::BYTE_W'($urandom_range(65, 90));
            3, 4:    return lah_pkg::BYTE_W'($urandom_range(97, 122));
            5:
            begin
                case ($urandom_range(0, 3))
                    0:       return 8'd64;
                    1:       return 8'd91;
                    2:       return 8'd96;
                    default: return 8'd123;
                endcase
            end
            default: return lah_pkg::BYTE_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic send_string(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_byte(pick_byte(), i == len - 1);
        end
    endtask

    initial
    begin
        int roll;
        logic [lah_pkg::BYTE_W-1:0] singles[10];
        logic [lah_pkg::BYTE_W-1:0] word[6];
        singles = '{8'd1, 8'd255, 8'd65, 8'd90, 8'd64, 8'd91, 8'd97, 8'd122,
                    8'd0, 8'd128};
        word = '{8'd65, 8'd98, 8'd67, 8'd57, 8'd122, 8'd90};
        char_bus.valid <= 1'b0;
        char_bus.data_byte <= '0;
        char_bus.end_of_string <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (singles[i])
        begin
            send_byte(singles[i], 1'b1);
        end
        foreach (word[i])
        begin
            send_byte(word[i], i == 5);
        end
        send_byte(8'd255, 1'b0);
        send_byte(8'd0, 1'b0);
        send_byte(8'd255, 1'b1);
        wait_drained();

        // low sum lands exactly on the modulus
        for (int i = 0; i < 256; i++)
        begin
            send_byte(8'd255, 1'b0);
        end
        send_byte(8'd241, 1'b1);

        while (bytes_sent < 1500)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                idling_on = !idling_on;
            end
            if (bytes_sent > 1300)
            begin
                idling_on = 1'b0;
            end
            roll = $urandom_range(0, 99);
            if (roll < 90)
            begin
                send_string($urandom_range(1, 12));
            end
            else if (roll < 98)
            begin
                send_string($urandom_range(13, 64));
            end
            else
            begin
                send_string($urandom_range(200, 400));
            end
            if (!pressure_done && bytes_sent > 900)
            begin
                pressure_done = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        end_of_run <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS lowercase_adler_hash");
        end
        else
        begin
            $display("FAIL lowercase_adler_hash");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/lah_pkg.sv
rtl/core/lah_char_if.sv
rtl/core/lah_hash_if.sv
rtl/core/lah_sum_update.sv
rtl/core/lowercase_adler_hash.sv
sim/lah_hash_checker.sv
sim/tb.sv
